/* rtl/adsr_pkg.sv */
package adsr_pkg;

	// field widths
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int LEVEL_BITS  = 9;
	localparam int PERIOD_BITS = 16;
	localparam int ACTION_BITS = 2;
	localparam int STAGE_BITS  = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// full scale level and the matching shift
	localparam int FULL_LEVEL  = 256;
	localparam int LEVEL_SHIFT = 8;

	// product of a sample and a level, level taken as signed
	localparam int PROD_BITS = SAMPLE_BITS + LEVEL_BITS + 1;

	// action codes
	localparam logic [ACTION_BITS-1:0] ACT_SAMPLE   = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_GATE_ON  = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_GATE_OFF = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SUSTAIN = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS  = 3'd4;

	// register reset values
	localparam logic [PERIOD_BITS-1:0] ATTACK_RESET  = 16'd93;
	localparam logic [PERIOD_BITS-1:0] DECAY_RESET   = 16'd375;
	localparam logic [PERIOD_BITS-1:0] RELEASE_RESET = 16'd5;
	localparam logic [LEVEL_BITS-1:0]  SUSTAIN_RESET = 9'd225;

endpackage

/* rtl/adsr_envelope_gain.sv */
// Linear ADSR envelope applied as a gain to a stream of signed audio samples.
// Gate-on and gate-off requests only steer the envelope and give no result;
// every audio sample request gives one result: the sample times the envelope
// level over 256 (truncated toward zero), the level that was used and the
// envelope stage. One request is taken in every cycle unless in_stall is
// high; the envelope stage, level and frame tick counter are updated in the
// cycle a request is taken, and the multiply sits in the stage after that.
// When the result register is stalled and the sample stage is also full, the
// sample stage holds and in_stall rises in the same cycle (the stall passes
// back combinationally); with the sample stage empty a request is still taken.
// Configuration is written through cfg_we/cfg_index/cfg_data; bypass passes
// samples unchanged and freezes the envelope, gate requests still act.
module adsr_envelope_gain import adsr_pkg::*; (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]         cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ACTION_BITS-1:0]           action,
	input  logic signed [SAMPLE_BITS-1:0]    sample_in,
	input  logic                             frame_start,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [SAMPLE_BITS-1:0]    sample_out,
	output logic [LEVEL_BITS-1:0]            envelope_level,
	output logic [STAGE_BITS-1:0]            stage
);

	typedef enum logic [STAGE_BITS-1:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	localparam logic [LEVEL_BITS-1:0]  LEVEL_FULL = LEVEL_BITS'(FULL_LEVEL);
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
	localparam logic [PROD_BITS-1:0]   TRUNC_BIAS = PROD_BITS'(FULL_LEVEL - 1);

	// configuration registers
	logic [PERIOD_BITS-1:0] attack_period_q;
	logic [PERIOD_BITS-1:0] decay_period_q;
	logic [PERIOD_BITS-1:0] release_period_q;
	logic [LEVEL_BITS-1:0]  sustain_level_q;
	logic                   bypass_q;

	// envelope state
	stage_t                 stage_q;
	logic [LEVEL_BITS-1:0]  level_q;
	logic [COUNT_BITS-1:0]  tick_q;

	// sample stage
	logic                          valid_s1;
	logic                          bypass_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [LEVEL_BITS-1:0]         level_s1;
	stage_t                        stage_s1;

	// result stage
	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s2;
	logic [LEVEL_BITS-1:0]         level_s2;
	stage_t                        stage_s2;

	logic load_s2;
	logic load_s1;
	logic accept;
	logic step_env;

	stage_t                 stage_nxt;
	logic [LEVEL_BITS-1:0]  level_nxt;
	logic [COUNT_BITS-1:0]  tick_nxt;
	logic [COUNT_BITS-1:0]  tick_inc;
	logic [PERIOD_BITS-1:0] period_sel;
	logic                   reached;
	logic [LEVEL_BITS-1:0]  sus_clamped;
	logic signed [LEVEL_BITS:0] level_up;
	logic signed [LEVEL_BITS:0] level_down;

	logic signed [PROD_BITS-1:0] product;
	logic signed [PROD_BITS-1:0] product_adj;
	logic signed [SAMPLE_BITS-1:0] scaled;

	// pipeline flow control
	assign load_s2  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;
	assign accept   = in_valid && load_s1;
	assign step_env = accept && (action == ACT_SAMPLE) && !bypass_q;

	// saturating frame tick counter and period check
	always_comb begin
		tick_inc = tick_q;
		if (frame_start && tick_q != COUNT_MAX) begin
			tick_inc = tick_q + 1'b1;
		end
		case (stage_q)
			ST_ATTACK:  period_sel = attack_period_q;
			ST_DECAY:   period_sel = decay_period_q;
			ST_RELEASE: period_sel = release_period_q;
			default:    period_sel = '0;
		endcase
		reached = (COUNT_BITS'(period_sel) <= tick_inc);
		sus_clamped = (sustain_level_q > LEVEL_FULL) ? LEVEL_FULL : sustain_level_q;
		level_up    = $signed({1'b0, level_q}) + 10'sd1;
		level_down  = $signed({1'b0, level_q}) - 10'sd1;
	end

	// envelope next state
	always_comb begin
		stage_nxt = stage_q;
		level_nxt = level_q;
		tick_nxt  = tick_q;
		if (accept && action == ACT_GATE_ON) begin
			stage_nxt = ST_ATTACK;
		end else if (accept && action == ACT_GATE_OFF) begin
			if (stage_q != ST_IDLE) begin
				stage_nxt = ST_RELEASE;
			end
		end else if (step_env) begin
			tick_nxt = tick_inc;
			case (stage_q)
				ST_ATTACK: begin
					if (reached) begin
						tick_nxt = '0;
						if (level_up >= $signed({1'b0, LEVEL_FULL})) begin
							level_nxt = LEVEL_FULL;
							stage_nxt = ST_DECAY;
						end else begin
							level_nxt = level_up[LEVEL_BITS-1:0];
						end
					end
				end
				ST_DECAY: begin
					if (reached) begin
						tick_nxt = '0;
						if (level_down <= $signed({1'b0, sus_clamped})) begin
							level_nxt = sus_clamped;
							stage_nxt = ST_SUSTAIN;
						end else begin
							level_nxt = level_down[LEVEL_BITS-1:0];
						end
					end
				end
				ST_RELEASE: begin
					if (reached) begin
						tick_nxt = '0;
						if (level_down <= 10'sd0) begin
							level_nxt = '0;
							stage_nxt = ST_IDLE;
						end else begin
							level_nxt = level_down[LEVEL_BITS-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// gain: sample times level over full scale, truncated toward zero
	always_comb begin
		product     = PROD_BITS'(sample_s1) * $signed({1'b0, level_s1});
		product_adj = product + (product[PROD_BITS-1] ? TRUNC_BIAS : '0);
		scaled      = product_adj[LEVEL_SHIFT +: SAMPLE_BITS];
	end

	// configuration, envelope state and pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_period_q  <= ATTACK_RESET;
			decay_period_q   <= DECAY_RESET;
			release_period_q <= RELEASE_RESET;
			sustain_level_q  <= SUSTAIN_RESET;
			bypass_q         <= 1'b0;
			stage_q          <= ST_IDLE;
			level_q          <= '0;
			tick_q           <= '0;
			valid_s1         <= 1'b0;
			bypass_s1        <= 1'b0;
			sample_s1        <= '0;
			level_s1         <= '0;
			stage_s1         <= ST_IDLE;
			valid_s2         <= 1'b0;
			sample_s2        <= '0;
			level_s2         <= '0;
			stage_s2         <= ST_IDLE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ATTACK:  attack_period_q  <= cfg_data[PERIOD_BITS-1:0];
					REG_DECAY:   decay_period_q   <= cfg_data[PERIOD_BITS-1:0];
					REG_RELEASE: release_period_q <= cfg_data[PERIOD_BITS-1:0];
					REG_SUSTAIN: sustain_level_q  <= cfg_data[LEVEL_BITS-1:0];
					REG_BYPASS:  bypass_q         <= cfg_data[0];
					default: begin
					end
				endcase
			end
			stage_q <= stage_nxt;
			level_q <= level_nxt;
			tick_q  <= tick_nxt;
			if (load_s1) begin
				valid_s1  <= accept && (action == ACT_SAMPLE);
				bypass_s1 <= bypass_q;
				sample_s1 <= sample_in;
				level_s1  <= level_nxt;
				stage_s1  <= stage_nxt;
			end
			if (load_s2) begin
				valid_s2  <= valid_s1;
				sample_s2 <= bypass_s1 ? sample_s1 : scaled;
				level_s2  <= level_s1;
				stage_s2  <= stage_s1;
			end
		end
	end

	assign out_valid      = valid_s2;
	assign sample_out     = sample_s2;
	assign envelope_level = level_s2;
	assign stage          = stage_s2;

`ifndef ASSERT_OFF
	// level stays within full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LEVEL_FULL)
		else $error("envelope level above full scale");

	// idle is only reached with the level at zero
	a_idle_level: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == ST_IDLE |-> level_q == '0)
		else $error("idle stage with nonzero level");

	// input is held back only behind a full, stalled pipeline
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a full pipeline");

	// a waiting sample is kept while the result register is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |=> (valid_s1 && $stable(sample_s1)))
		else $error("sample stage lost while stalled");
`endif

endmodule
